[hw/rtl/aef_pkg.sv]
// Shared types and constants for the encoder frame unwrap block.
`timescale 1ns / 1ps

package aef_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PosW     = 14;
  localparam int unsigned StepW    = 15;
  localparam int unsigned OffsW    = 17;
  localparam int unsigned HomeW    = 15;
  localparam int unsigned RateW    = 16;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned SpeedW   = 30;
  localparam int unsigned ErrW     = 16;

  localparam logic [1:0] CheckSeed = 2'h3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RES14   = 2'd0,
    REG_REVERSE = 2'd1,
    REG_HOME    = 2'd2,
    REG_RATE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_POS   = 2'd0,
    KIND_BAD   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef struct packed {
    logic                    res14;
    logic                    reverse;
    logic signed [HomeW-1:0] home;
    logic [RateW-1:0]        rate;
  } cfg_t;

  // one classified beat waiting for the back end
  typedef struct packed {
    kind_e                   kind;
    logic [PosW-1:0]         pos;
    logic signed [StepW-1:0] step;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[hw/rtl/absolute_encoder_frame_unwrap.sv]
// Top level: configuration registers, front end, queue and back end.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o  | cmd, frame_low, frame_high
//  out     | output    | out_valid_o / out_ready_i | check_ok .. error_count
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One frame per cycle while the queue is not full; a result passes through the
// queue write, then the output register. The step against the previous offset
// is resolved in the front end in the accepting cycle; total, error count and
// speed product are formed at queue pop. Reset zeroes cfg and all state but
// queue storage and the check, step and speed registers. A stalled output
// holds its beat while up to two more frames are queued; cfg is always ready.
`timescale 1ns / 1ps

module absolute_encoder_frame_unwrap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [7:0]                          frame_low_i,
  input  logic [7:0]                          frame_high_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                check_ok_o,
  output logic [aef_pkg::PosW-1:0]            position_count_o,
  output logic signed [aef_pkg::StepW-1:0]    step_count_o,
  output logic signed [aef_pkg::TotalW-1:0]   total_count_o,
  output logic signed [aef_pkg::SpeedW-1:0]   speed_counts_o,
  output logic [aef_pkg::ErrW-1:0]            error_count_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aef_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [aef_pkg::CfgDataW-1:0]        cfg_data_i
);
  import aef_pkg::*;

  cfg_t         cfg_q, cfg_d;
  entry_t       front_entry;
  entry_t       back_entry;
  fifo_status_t fifo_status;
  logic         in_accept;
  logic         pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !fifo_status.full;
  assign in_accept   = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_RES14:   cfg_d.res14   = cfg_data_i[0];
        REG_REVERSE: cfg_d.reverse = cfg_data_i[0];
        REG_HOME:    cfg_d.home    = $signed(cfg_data_i[HomeW-1:0]);
        REG_RATE:    cfg_d.rate    = cfg_data_i[RateW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  aef_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (in_accept),
    .cmd_i        (cmd_i),
    .frame_low_i  (frame_low_i),
    .frame_high_i (frame_high_i),
    .entry_o      (front_entry)
  );

  aef_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_entry),
    .pop_i       (pop),
    .pop_data_o  (back_entry),
    .status_o    (fifo_status)
  );

  aef_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .avail_i          (!fifo_status.empty),
    .entry_i          (back_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .check_ok_o       (check_ok_o),
    .position_count_o (position_count_o),
    .step_count_o     (step_count_o),
    .total_count_o    (total_count_o),
    .speed_counts_o   (speed_counts_o),
    .error_count_o    (error_count_o)
  );

endmodule

[hw/rtl/aef_front.sv]
// Front end: check bits, position masking, offset and wrapped step.
`timescale 1ns / 1ps

module aef_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aef_pkg::cfg_t        cfg_i,
  input  logic                 accept_i,
  input  logic                 cmd_i,
  input  logic [7:0]           frame_low_i,
  input  logic [7:0]           frame_high_i,
  output aef_pkg::entry_t      entry_o
);
  import aef_pkg::*;

  logic [15:0]              word;
  logic [1:0]               check;
  logic                     good;
  logic [PosW-1:0]          pos;
  logic signed [OffsW-1:0]  offs_raw;
  logic signed [OffsW-1:0]  offs;
  logic signed [OffsW:0]    diff;
  logic [PosW-1:0]          r;
  logic [PosW-1:0]          half;
  logic [StepW:0]           cpr;
  logic signed [StepW-1:0]  step;
  logic signed [OffsW-1:0]  prev_q;
  logic signed [OffsW-1:0]  prev_d;

  assign word  = {frame_high_i, frame_low_i};
  assign check = CheckSeed ^ word[1:0] ^ word[3:2] ^ word[5:4] ^ word[7:6]
               ^ word[9:8] ^ word[11:10] ^ word[13:12];
  assign good  = (check == word[15:14]);

  always_comb begin
    pos      = cfg_i.res14 ? word[PosW-1:0] : {2'b00, word[11:0]};
    offs_raw = $signed({3'b000, pos}) - OffsW'(cfg_i.home);
    offs     = cfg_i.reverse ? -offs_raw : offs_raw;
    diff     = (OffsW+1)'(offs) - (OffsW+1)'(prev_q);
    r        = cfg_i.res14 ? diff[PosW-1:0] : {2'b00, diff[11:0]};
    half     = cfg_i.res14 ? PosW'(8192) : PosW'(2048);
    cpr      = cfg_i.res14 ? (StepW+1)'(16384) : (StepW+1)'(4096);
    if (r > half) begin
      step = StepW'({2'b00, r} - cpr);
    end else if (r == half && diff[OffsW]) begin
      step = -$signed({1'b0, half});
    end else begin
      step = $signed({1'b0, r});
    end
  end

  always_comb begin
    entry_o.pos  = pos;
    entry_o.step = '0;
    if (cmd_i) begin
      entry_o.kind = KIND_CLEAR;
    end else if (!good) begin
      entry_o.kind = KIND_BAD;
    end else begin
      entry_o.kind = KIND_POS;
      entry_o.step = step;
    end
  end

  assign prev_d = (accept_i && !cmd_i && good) ? offs : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

[hw/rtl/aef_fifo.sv]
// Two-entry queue between front and back end.
`timescale 1ns / 1ps

module aef_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  aef_pkg::entry_t       push_data_i,
  input  logic                  pop_i,
  output aef_pkg::entry_t       pop_data_o,
  output aef_pkg::fifo_status_t status_o
);
  import aef_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign pop_data_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d  = push_i ? ~wptr_q : wptr_q;
    rptr_d  = pop_i ? ~rptr_q : rptr_q;
    count_d = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/aef_back.sv]
// Back end: running total, error count, speed and the output register.
`timescale 1ns / 1ps

module aef_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  aef_pkg::cfg_t                       cfg_i,
  input  logic                                avail_i,
  input  aef_pkg::entry_t                     entry_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                check_ok_o,
  output logic [aef_pkg::PosW-1:0]            position_count_o,
  output logic signed [aef_pkg::StepW-1:0]    step_count_o,
  output logic signed [aef_pkg::TotalW-1:0]   total_count_o,
  output logic signed [aef_pkg::SpeedW-1:0]   speed_counts_o,
  output logic [aef_pkg::ErrW-1:0]            error_count_o
);
  import aef_pkg::*;

  logic                     valid_q, valid_d;
  logic [PosW-1:0]          last_pos_q, last_pos_d;
  logic [TotalW-1:0]        total_q, total_d;
  logic [ErrW-1:0]          err_q, err_d;
  logic                     ok_q, ok_d;
  logic signed [StepW-1:0]  step_q;
  logic signed [SpeedW-1:0] speed_q;
  logic signed [31:0]       product;

  assign pop_o   = avail_i && (!valid_q || out_ready_i);
  assign product = 32'(entry_i.step) * $signed({1'b0, cfg_i.rate});

  always_comb begin
    last_pos_d = last_pos_q;
    total_d    = total_q;
    err_d      = err_q;
    ok_d       = 1'b0;
    case (entry_i.kind)
      KIND_POS: begin
        ok_d       = 1'b1;
        last_pos_d = entry_i.pos;
        total_d    = total_q + TotalW'(entry_i.step);
      end
      KIND_BAD: begin
        err_d = err_q + 1'b1;
      end
      KIND_CLEAR: begin
        total_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      last_pos_q <= '0;
      total_q    <= '0;
      err_q      <= '0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        last_pos_q <= last_pos_d;
        total_q    <= total_d;
        err_q      <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q    <= ok_d;
      step_q  <= entry_i.step;
      speed_q <= product[SpeedW-1:0];
    end
  end

  assign out_valid_o      = valid_q;
  assign check_ok_o       = ok_q;
  assign position_count_o = last_pos_q;
  assign step_count_o     = step_q;
  assign total_count_o    = total_q;
  assign speed_counts_o   = speed_q;
  assign error_count_o    = err_q;

endmodule

[hw/rtl/aef_checker.sv]
// Port-level checks for the encoder frame unwrap block, with bind.
`timescale 1ns / 1ps

module aef_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic                              check_ok_o,
  input logic signed [aef_pkg::StepW-1:0]  step_count_o,
  input logic signed [aef_pkg::SpeedW-1:0] speed_counts_o,
  input logic [aef_pkg::ErrW-1:0]          error_count_o
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(step_count_o)
      && $stable(error_count_o))
    else $error("result beat dropped under stall");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !check_ok_o |-> step_count_o == '0 && speed_counts_o == '0)
    else $error("failed or clear beat carries a step");

  a_speed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && step_count_o == '0 |-> speed_counts_o == '0)
    else $error("speed without step");

  // step never exceeds half a 14-bit revolution
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(!step_count_o[14] && step_count_o[13:0] > 14'd8192))
    else $error("step outside half revolution");

endmodule

bind absolute_encoder_frame_unwrap aef_checker u_aef_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .check_ok_o     (check_ok_o),
  .step_count_o   (step_count_o),
  .speed_counts_o (speed_counts_o),
  .error_count_o  (error_count_o)
);
